FILE: rtl/amr_pkg.sv
// Shared types and constants for the four-channel audio mixer/resampler.
// No dependencies; the files that use it refer to it by scoped names.
package amr_pkg;

	typedef logic [4:0]  level_t;
	typedef logic [1:0]  cfg_idx_t;
	typedef logic [23:0] cfg_data_t;

	localparam cfg_idx_t CFG_CLOCK_RATE    = 2'd0;
	localparam cfg_idx_t CFG_SAMPLE_RATE   = 2'd1;
	localparam cfg_idx_t CFG_FILTER_CHARGE = 2'd2;

	localparam logic [23:0] CLOCK_RATE_RST    = 24'd4194304;
	localparam logic [17:0] SAMPLE_RATE_RST   = 18'd44100;
	localparam logic [15:0] FILTER_CHARGE_RST = 16'd65275;

	localparam level_t LEVEL_SILENT = 5'd16;

	// ceil(2^27 / 15): sum * 2048 / 15 == (|sum| * RECIP_15) >> 16
	localparam logic [23:0] RECIP_15 = 24'd8947849;
	localparam logic signed [16:0] SAMPLE_SCALE = 17'sd32767;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MIX,
		ST_PHASE,
		ST_FLT_X,
		ST_FLT_OUT,
		ST_FLT_MUL,
		ST_FLT_CAP
	} state_t;

	typedef struct packed {
		logic       load;
		logic       mix;
		logic [1:0] ch;
		logic       phase;
		logic       flt_x;
		logic       flt_out;
		logic       flt_mul;
		logic       flt_cap;
	} cmd_t;

	typedef struct packed {
		logic fire;
		logic out_busy;
	} sts_t;

endpackage

FILE: rtl/amr_tick_if.sv
// Input channel: one audio sub-tick per transaction.
// Depends on amr_pkg.
interface amr_tick_if;
	logic            valid;
	logic            ready;
	amr_pkg::level_t level_one;
	amr_pkg::level_t level_two;
	amr_pkg::level_t level_three;
	amr_pkg::level_t level_four;
	logic [7:0]      panning;
	logic [7:0]      mix_volume;
	logic [3:0]      channel_enable;

	modport source (output valid, level_one, level_two, level_three, level_four,
		panning, mix_volume, channel_enable, input ready);
	modport sink (input valid, level_one, level_two, level_three, level_four,
		panning, mix_volume, channel_enable, output ready);
endinterface

FILE: rtl/amr_smp_if.sv
// Output channel: one stereo sample pair per transaction.
// No dependencies.
interface amr_smp_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] left_sample;
	logic signed [15:0] right_sample;

	modport source (output valid, left_sample, right_sample, input ready);
	modport sink (input valid, left_sample, right_sample, output ready);
endinterface

FILE: rtl/amr_cfg_if.sv
// Configuration write channel: register index and write data.
// Depends on amr_pkg.
interface amr_cfg_if;
	logic                 valid;
	logic                 ready;
	amr_pkg::cfg_idx_t    index;
	amr_pkg::cfg_data_t   data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/amr_dp.sv
// Datapath: config registers, level mixing, phase accumulator, DC-blocking
// filter and output register. Driven by amr_ctrl commands; depends on amr_pkg.
module amr_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  amr_pkg::cmd_t       cmd,
	output amr_pkg::sts_t       sts,
	input  amr_pkg::level_t     level_one,
	input  amr_pkg::level_t     level_two,
	input  amr_pkg::level_t     level_three,
	input  amr_pkg::level_t     level_four,
	input  logic [7:0]          panning,
	input  logic [7:0]          mix_volume,
	input  logic [3:0]          channel_enable,
	input  logic                cfg_we,
	input  amr_pkg::cfg_idx_t   cfg_index,
	input  amr_pkg::cfg_data_t  cfg_data,
	output logic                out_valid,
	input  logic                out_ready,
	output logic signed [15:0]  left_sample,
	output logic signed [15:0]  right_sample
);

	function automatic logic signed [5:0] half_units(input amr_pkg::level_t lvl);
		logic signed [5:0] hu;
		if (lvl >= amr_pkg::LEVEL_SILENT) begin
			hu = 6'sd0;
		end else begin
			hu = $signed({lvl, 1'b0}) - 6'sd15;
		end
		return hu;
	endfunction

	logic [23:0]        clock_rate_q;
	logic [17:0]        sample_rate_q;
	logic [15:0]        filter_charge_q;

	amr_pkg::level_t    lvl_q  [4];
	amr_pkg::level_t    prev_q [4];
	logic [7:0]         pan_q;
	logic [7:0]         vol_q;
	logic [3:0]         en_q;

	logic signed [11:0] sum_q [2];
	logic signed [19:0] cap_q [2];
	logic [23:0]        acc_q;

	logic [35:0]        prod_s1 [2];
	logic               neg_s1  [2];
	logic signed [19:0] x_s2    [2];
	logic signed [20:0] out_s2  [2];
	logic signed [37:0] pf_s3   [2];
	logic signed [37:0] ps_s3   [2];

	logic               out_valid_q;
	logic signed [15:0] left_q;
	logic signed [15:0] right_q;

	amr_pkg::level_t    now_lvl;
	amr_pkg::level_t    before_lvl;
	logic signed [6:0]  delta;
	logic [2:0]         vol_code [2];
	logic               route    [2];
	logic signed [11:0] term     [2];
	logic signed [12:0] sum_wide [2];
	logic signed [11:0] sum_next [2];

	logic [24:0]        acc_sum;
	logic [24:0]        acc_sub;
	logic               fire;
	logic [23:0]        acc_next;

	logic [11:0]        mag      [2];
	logic [18:0]        quot     [2];
	logic signed [19:0] x_val    [2];
	logic signed [21:0] fl_val   [2];
	logic signed [22:0] cap_wide [2];
	logic signed [19:0] cap_next [2];
	logic signed [37:0] ps_adj   [2];
	logic signed [21:0] smp_wide [2];
	logic signed [15:0] smp_next [2];

	always_comb begin
		now_lvl     = lvl_q[cmd.ch];
		before_lvl  = prev_q[cmd.ch];
		delta       = 7'(half_units(now_lvl)) - 7'(half_units(before_lvl));
		vol_code[0] = vol_q[6:4];
		vol_code[1] = vol_q[2:0];
		route[0]    = en_q[cmd.ch] & pan_q[{1'b1, cmd.ch}];
		route[1]    = en_q[cmd.ch] & pan_q[{1'b0, cmd.ch}];
		for (int s = 0; s < 2; s++) begin
			term[s] = delta * $signed({1'b0, {1'b0, vol_code[s]} + 4'd1});
			sum_wide[s] = {sum_q[s][11], sum_q[s]} + {term[s][11], term[s]};
			if (sum_wide[s] > 13'sd2047) begin
				sum_next[s] = 12'sd2047;
			end else if (sum_wide[s] < -13'sd2048) begin
				sum_next[s] = -12'sd2048;
			end else begin
				sum_next[s] = sum_wide[s][11:0];
			end
		end
	end

	always_comb begin
		acc_sum  = {1'b0, acc_q} + {7'd0, sample_rate_q};
		fire     = acc_sum >= {1'b0, clock_rate_q};
		acc_sub  = acc_sum - {1'b0, clock_rate_q};
		acc_next = acc_sub[24] ? 24'hFFFFFF : acc_sub[23:0];
	end

	always_comb begin
		for (int s = 0; s < 2; s++) begin
			mag[s]   = sum_q[s][11] ? (~sum_q[s] + 12'd1) : sum_q[s];
			quot[s]  = prod_s1[s][34:16];
			x_val[s] = neg_s1[s] ? -$signed({1'b0, quot[s]}) : $signed({1'b0, quot[s]});
			fl_val[s]   = pf_s3[s][37:16];
			cap_wide[s] = {{3{x_s2[s][19]}}, x_s2[s]} - {fl_val[s][21], fl_val[s]};
			if (cap_wide[s] > 23'sd524287) begin
				cap_next[s] = 20'sd524287;
			end else if (cap_wide[s] < -23'sd524288) begin
				cap_next[s] = -20'sd524288;
			end else begin
				cap_next[s] = cap_wide[s][19:0];
			end
			ps_adj[s]   = ps_s3[s][37] ? (ps_s3[s] + 38'sd65535) : ps_s3[s];
			smp_wide[s] = ps_adj[s][37:16];
			if (smp_wide[s] > 22'sd32767) begin
				smp_next[s] = 16'sd32767;
			end else if (smp_wide[s] < -22'sd32768) begin
				smp_next[s] = -16'sd32768;
			end else begin
				smp_next[s] = smp_wide[s][15:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_rate_q    <= amr_pkg::CLOCK_RATE_RST;
			sample_rate_q   <= amr_pkg::SAMPLE_RATE_RST;
			filter_charge_q <= amr_pkg::FILTER_CHARGE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				amr_pkg::CFG_CLOCK_RATE:    clock_rate_q    <= cfg_data;
				amr_pkg::CFG_SAMPLE_RATE:   sample_rate_q   <= cfg_data[17:0];
				amr_pkg::CFG_FILTER_CHARGE: filter_charge_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < 4; c++) begin
				prev_q[c] <= amr_pkg::LEVEL_SILENT;
			end
			for (int s = 0; s < 2; s++) begin
				sum_q[s] <= '0;
				cap_q[s] <= '0;
			end
			acc_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.mix) begin
				prev_q[cmd.ch] <= now_lvl;
				for (int s = 0; s < 2; s++) begin
					if (route[s]) begin
						sum_q[s] <= sum_next[s];
					end
				end
			end
			if (cmd.phase) begin
				acc_q <= fire ? acc_next : acc_sum[23:0];
			end
			if (cmd.flt_cap) begin
				for (int s = 0; s < 2; s++) begin
					cap_q[s] <= cap_next[s];
				end
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			lvl_q[0] <= level_one;
			lvl_q[1] <= level_two;
			lvl_q[2] <= level_three;
			lvl_q[3] <= level_four;
			pan_q    <= panning;
			vol_q    <= mix_volume;
			en_q     <= channel_enable;
		end
		for (int s = 0; s < 2; s++) begin
			if (cmd.flt_x) begin
				prod_s1[s] <= {24'd0, mag[s]} * {12'd0, amr_pkg::RECIP_15};
				neg_s1[s]  <= sum_q[s][11];
			end
			if (cmd.flt_out) begin
				x_s2[s]   <= x_val[s];
				out_s2[s] <= {x_val[s][19], x_val[s]} - {cap_q[s][19], cap_q[s]};
			end
			if (cmd.flt_mul) begin
				pf_s3[s] <= out_s2[s] * $signed({1'b0, filter_charge_q});
				ps_s3[s] <= out_s2[s] * amr_pkg::SAMPLE_SCALE;
			end
		end
		if (cmd.flt_cap) begin
			left_q  <= smp_next[0];
			right_q <= smp_next[1];
		end
	end

	assign sts.fire     = fire;
	assign sts.out_busy = out_valid_q & ~out_ready;
	assign out_valid    = out_valid_q;
	assign left_sample  = left_q;
	assign right_sample = right_q;

endmodule

FILE: rtl/amr_ctrl.sv
// Controller: sequences accept, per-channel mix, phase step and filter stages.
// Depends on amr_pkg; drives amr_dp through cmd_t and reads sts_t.
module amr_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  amr_pkg::sts_t sts,
	output amr_pkg::cmd_t cmd
);

	amr_pkg::state_t state_q;
	amr_pkg::state_t state_nxt;
	logic [1:0]      ch_q;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			amr_pkg::ST_IDLE:    if (in_valid) state_nxt = amr_pkg::ST_MIX;
			amr_pkg::ST_MIX:     if (ch_q == 2'd3) state_nxt = amr_pkg::ST_PHASE;
			amr_pkg::ST_PHASE: begin
				state_nxt = sts.fire ? amr_pkg::ST_FLT_X : amr_pkg::ST_IDLE;
			end
			amr_pkg::ST_FLT_X:   state_nxt = amr_pkg::ST_FLT_OUT;
			amr_pkg::ST_FLT_OUT: state_nxt = amr_pkg::ST_FLT_MUL;
			amr_pkg::ST_FLT_MUL: state_nxt = amr_pkg::ST_FLT_CAP;
			amr_pkg::ST_FLT_CAP: if (!sts.out_busy) state_nxt = amr_pkg::ST_IDLE;
			default:             state_nxt = amr_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		cmd.ch   = ch_q;
		in_ready = 1'b0;
		unique case (state_q)
			amr_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			amr_pkg::ST_MIX:     cmd.mix     = 1'b1;
			amr_pkg::ST_PHASE:   cmd.phase   = 1'b1;
			amr_pkg::ST_FLT_X:   cmd.flt_x   = 1'b1;
			amr_pkg::ST_FLT_OUT: cmd.flt_out = 1'b1;
			amr_pkg::ST_FLT_MUL: cmd.flt_mul = 1'b1;
			amr_pkg::ST_FLT_CAP: cmd.flt_cap = ~sts.out_busy;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= amr_pkg::ST_IDLE;
			ch_q    <= 2'd0;
		end else begin
			state_q <= state_nxt;
			if (state_q == amr_pkg::ST_MIX) begin
				ch_q <= ch_q + 2'd1;
			end
		end
	end

endmodule

FILE: rtl/four_channel_audio_mixer_resampler_core.sv
// Top level of the four-channel audio mixer/resampler.
// Depends on amr_pkg, amr_tick_if, amr_smp_if, amr_cfg_if, amr_ctrl, amr_dp.
//
//   channel | dir | payload                                       | sync
//   tick    | in  | four levels, panning, mix_volume, enables     | valid/ready
//   samples | out | left_sample, right_sample                     | valid/ready
//   cfg     | in  | index (0 clock, 1 sample rate, 2 charge), data| valid/ready
//
// A tick steps through accept, the mix loop over the four channels and a phase step.
// A tick that produces a sample then passes four more filter stages.
// tick.ready is high only in the idle state; cfg.ready is always high.
// A held output stalls the last filter stage until it is taken.
// arst_n clears sums, capacitors, accumulator and restores the register defaults.
module four_channel_audio_mixer_resampler_core (
	input  logic     clk,
	input  logic     arst_n,
	amr_tick_if.sink tick,
	amr_smp_if.source samples,
	amr_cfg_if.sink  cfg
);

	amr_pkg::cmd_t cmd;
	amr_pkg::sts_t sts;

	assign cfg.ready = 1'b1;

	amr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (tick.valid),
		.in_ready (tick.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	amr_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.level_one      (tick.level_one),
		.level_two      (tick.level_two),
		.level_three    (tick.level_three),
		.level_four     (tick.level_four),
		.panning        (tick.panning),
		.mix_volume     (tick.mix_volume),
		.channel_enable (tick.channel_enable),
		.cfg_we         (cfg.valid),
		.cfg_index      (cfg.index),
		.cfg_data       (cfg.data),
		.out_valid      (samples.valid),
		.out_ready      (samples.ready),
		.left_sample    (samples.left_sample),
		.right_sample   (samples.right_sample)
	);

endmodule
